// ----- rtl/core/asc_pkg.sv -----
// Shared constants, codes and handshake structs for the ADC scan sequencer.
// Depends on nothing; every module of the block imports it.
package asc_pkg;

    // Geometry of the scan and of the per-channel sample rings
    localparam int CHANNELS  = 4;
    localparam int RING_LOG2 = 4;
    localparam int RING_SIZE = 1 << RING_LOG2;

    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W    = (RING_LOG2 > 0) ? RING_LOG2 : 1;
    localparam int ADDR_W   = (CHANNELS * RING_SIZE > 1) ? $clog2(CHANNELS * RING_SIZE) : 1;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = SAMPLE_W + RING_LOG2;

    // Operation codes of an input word
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_DONE  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_DELAY   = 2'd1;
    localparam logic [1:0] CFG_ROUNDS  = 2'd2;

    // Sequencer modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WAIT  = 2'd1;
    localparam logic [1:0] MODE_DELAY = 2'd2;

    // Channel status codes returned by a query
    localparam logic [1:0] CHST_BUSY  = 2'd0;
    localparam logic [1:0] CHST_READY = 2'd1;
    localparam logic [1:0] CHST_ERROR = 2'd2;

    localparam logic [15:0] MEAN_NONE = 16'hFFFF;

    // Launch of an averaging pass
    typedef struct packed {
        logic            go;
        logic [CH_W-1:0] ch;
    } avg_ctrl_t;

    // Outcome of an averaging pass
    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] mean;
    } avg_stat_t;

endpackage

// ----- rtl/core/asc_ring_mem.sv -----
// Sample ring storage: one write port, one registered read port.
// Depends on asc_pkg for the address and sample widths.
module asc_ring_mem (
    input  logic                         clk,
    input  logic                         we,
    input  logic [asc_pkg::ADDR_W-1:0]   waddr,
    input  logic [asc_pkg::SAMPLE_W-1:0] wdata,
    input  logic                         re,
    input  logic [asc_pkg::ADDR_W-1:0]   raddr,
    output logic [asc_pkg::SAMPLE_W-1:0] rdata
);
    import asc_pkg::*;

    logic [SAMPLE_W-1:0] mem [CHANNELS * RING_SIZE];
    logic [SAMPLE_W-1:0] rdata_reg;

    // Store a sample
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/asc_avg_unit.sv -----
// Iterative boxcar averager: walks one channel's ring through the read port,
// one word a cycle, into a single accumulator. Depends on asc_pkg.
module asc_avg_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  asc_pkg::avg_ctrl_t           ctrl,
    output asc_pkg::avg_stat_t           stat,
    output logic                         re,
    output logic [asc_pkg::ADDR_W-1:0]   raddr,
    input  logic [asc_pkg::SAMPLE_W-1:0] rdata
);
    import asc_pkg::*;

    logic             active_reg;
    logic [POS_W-1:0] cnt_reg;
    logic [CH_W-1:0]  ch_reg;
    logic             pend_reg;
    logic             pend_last_reg;
    logic             done_reg;
    logic [SUM_W-1:0] acc_reg;
    logic             last_issue;

    assign last_issue = (cnt_reg == POS_W'(RING_SIZE - 1));
    assign re         = active_reg;
    assign raddr      = ADDR_W'(ADDR_W'(ch_reg) * ADDR_W'(RING_SIZE)) + ADDR_W'(cnt_reg);

    // Issue one ring read a cycle until the last entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            pend_reg      <= active_reg;
            pend_last_reg <= active_reg && last_issue;
            done_reg      <= pend_last_reg;
            if (ctrl.go)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + POS_W'(1);
                if (last_issue)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    // Latch the channel and accumulate each returned word
    always_ff @(posedge clk)
    begin
        if (ctrl.go)
        begin
            ch_reg  <= ctrl.ch;
            acc_reg <= '0;
        end
        else if (pend_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(rdata);
        end
    end

    // Report completion and the mean of the ring
    assign stat = {done_reg, acc_reg[RING_LOG2 +: SAMPLE_W]};

endmodule

// ----- rtl/core/adc_scan_sequencer_with_averaging_top.sv -----
// Top level of the ADC scan sequencer with per-channel boxcar averaging.
// Depends on asc_pkg, asc_ring_mem and asc_avg_unit.
//
// Usage:
//  - An input word (op, sample, query_channel) is taken at a rising edge with
//    start high and busy low. Ops: start, stop, tick, conversion done, query.
//  - Every accepted word gives exactly one result word, shown for one cycle
//    with result_valid high; the receiver cannot hold it off.
//  - Start, stop, tick, conversion done and a query of a busy or out-of-range
//    channel need no averaging pass: the result follows the accepting edge, and
//    busy stays low, so such words may arrive every cycle.
//  - A query of a ready channel sums its ring through the single read port of
//    the ring memory, one entry a cycle, in the shared accumulator: the result
//    word is registered when the averager reports done, and busy is high until
//    the cycle of that result.
//  - Configuration (cfg_we, cfg_index, cfg_data) is taken at any edge with
//    cfg_we high; index 0 timeout, 1 channel delay, 2 scan rounds.
//  - Reset clears the sequencer to idle, all channels busy, registers to
//    1000 / 1 / 16 ticks/ticks/rounds. The ring memory needs no clearing: a
//    channel only turns ready once every entry of its ring has been rewritten.
module adc_scan_sequencer_with_averaging_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   op,
    input  logic [asc_pkg::SAMPLE_W-1:0] sample,
    input  logic [3:0]                   query_channel,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    output logic                         result_valid,
    output logic                         convert_request,
    output logic [3:0]                   convert_channel,
    output logic                         converter_stop,
    output logic                         busy_res,
    output logic [1:0]                   channel_state,
    output logic [15:0]                  mean_value
);
    import asc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SUM  = 1'b1;
    localparam int   POS_X_W = POS_W + 1;
    localparam int   CH_X_W  = CH_W + 1;

    // Configuration registers
    logic [15:0] timeout_reg;
    logic [15:0] delay_reg;
    logic [6:0]  rounds_cfg_reg;

    // Sequencer state
    logic             state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [CH_W-1:0]  cur_ch_reg, cur_ch_next;
    logic [6:0]       rounds_reg, rounds_next;
    logic [15:0]      countdown_reg, countdown_next;
    logic [POS_W-1:0] pos_reg [CHANNELS];
    logic [POS_W-1:0] pos_next [CHANNELS];
    logic [CHANNELS-1:0] ready_reg, ready_next;

    // Result registers
    logic        res_valid_reg, res_valid_next;
    logic        res_req_reg, res_req_next;
    logic [3:0]  res_ch_reg, res_ch_next;
    logic        res_stop_reg, res_stop_next;
    logic        res_busy_reg, res_busy_next;
    logic [1:0]  res_state_reg, res_state_next;
    logic [15:0] res_mean_reg, res_mean_next;

    // Helpers
    logic               accept;
    logic               q_in_range;
    logic [CH_W-1:0]    q_idx;
    logic [POS_W-1:0]   pos_cur;
    logic [POS_X_W-1:0] pos_inc;
    logic [CH_X_W-1:0]  ch_inc;
    logic [6:0]         rounds_inc;
    logic [6:0]         round_limit;
    logic               finish;

    // Ring memory and averager wiring
    avg_ctrl_t           ctrl;
    avg_stat_t           stat;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    assign busy       = (state_reg == ST_SUM);
    assign accept     = start && !busy;
    assign q_in_range = ({1'b0, query_channel} < 5'(CHANNELS));
    assign q_idx      = query_channel[CH_W-1:0];
    assign pos_cur    = pos_reg[cur_ch_reg];
    assign pos_inc    = {1'b0, pos_cur} + POS_X_W'(1);
    assign ch_inc     = {1'b0, cur_ch_reg} + CH_X_W'(1);
    assign rounds_inc = (rounds_reg == 7'd127) ? rounds_reg : rounds_reg + 7'd1;
    assign round_limit = (rounds_cfg_reg == 7'd0) ? 7'd1 : rounds_cfg_reg;
    assign ram_waddr  = ADDR_W'(ADDR_W'(cur_ch_reg) * ADDR_W'(RING_SIZE)) + ADDR_W'(pos_cur);

    asc_ring_mem u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    asc_avg_unit u_avg (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode one word and work out the next sequencer state and result
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cur_ch_next    = cur_ch_reg;
        rounds_next    = rounds_reg;
        countdown_next = countdown_reg;
        pos_next       = pos_reg;
        ready_next     = ready_reg;
        finish         = 1'b0;
        ram_we         = 1'b0;
        ctrl           = '0;
        res_valid_next = 1'b0;
        res_req_next   = 1'b0;
        res_ch_next    = '0;
        res_stop_next  = 1'b0;
        res_state_next = CHST_BUSY;
        res_mean_next  = '0;

        if (state_reg == ST_SUM)
        begin
            // Deliver the mean once the pass is over
            if (stat.done)
            begin
                state_next     = ST_IDLE;
                res_valid_next = 1'b1;
                res_state_next = CHST_READY;
                res_mean_next  = 16'(stat.mean);
            end
        end
        else if (accept)
        begin
            res_valid_next = 1'b1;
            case (op)
                OP_START:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        pos_next[i] = '0;
                    end
                    ready_next     = '0;
                    cur_ch_next    = '0;
                    rounds_next    = '0;
                    mode_next      = MODE_WAIT;
                    countdown_next = timeout_reg;
                    res_req_next   = 1'b1;
                end
                OP_STOP:
                begin
                    res_stop_next = 1'b1;
                    mode_next     = MODE_IDLE;
                end
                OP_TICK:
                begin
                    if (mode_reg == MODE_WAIT)
                    begin
                        if (countdown_reg <= 16'd1)
                        begin
                            res_stop_next = 1'b1;
                            mode_next     = MODE_IDLE;
                        end
                        else
                        begin
                            countdown_next = countdown_reg - 16'd1;
                        end
                    end
                    else if (mode_reg == MODE_DELAY)
                    begin
                        if (countdown_reg <= 16'd1)
                        begin
                            res_req_next   = 1'b1;
                            res_ch_next    = 4'(cur_ch_reg);
                            mode_next      = MODE_WAIT;
                            countdown_next = timeout_reg;
                        end
                        else
                        begin
                            countdown_next = countdown_reg - 16'd1;
                        end
                    end
                end
                OP_DONE:
                begin
                    if (mode_reg == MODE_WAIT)
                    begin
                        // Store the sample and advance the ring
                        ram_we = 1'b1;
                        if (pos_inc == POS_X_W'(RING_SIZE))
                        begin
                            pos_next[cur_ch_reg]   = '0;
                            ready_next[cur_ch_reg] = 1'b1;
                        end
                        else
                        begin
                            pos_next[cur_ch_reg] = pos_inc[POS_W-1:0];
                        end
                        // Advance the channel, count a round on wrap
                        if (ch_inc == CH_X_W'(CHANNELS))
                        begin
                            cur_ch_next = '0;
                            rounds_next = rounds_inc;
                            finish      = (rounds_inc >= round_limit);
                        end
                        else
                        begin
                            cur_ch_next = ch_inc[CH_W-1:0];
                        end
                        if (finish)
                        begin
                            mode_next = MODE_IDLE;
                        end
                        else if (delay_reg == 16'd0)
                        begin
                            res_req_next   = 1'b1;
                            res_ch_next    = 4'(cur_ch_next);
                            mode_next      = MODE_WAIT;
                            countdown_next = timeout_reg;
                        end
                        else
                        begin
                            mode_next      = MODE_DELAY;
                            countdown_next = delay_reg;
                        end
                    end
                end
                OP_QUERY:
                begin
                    if (!q_in_range)
                    begin
                        res_state_next = CHST_ERROR;
                        res_mean_next  = MEAN_NONE;
                    end
                    else if (!ready_reg[q_idx])
                    begin
                        res_state_next = CHST_BUSY;
                        res_mean_next  = MEAN_NONE;
                    end
                    else
                    begin
                        // Hand the ring to the averager and hold the result
                        res_valid_next = 1'b0;
                        ctrl.go        = 1'b1;
                        ctrl.ch        = q_idx;
                        state_next     = ST_SUM;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res_busy_next = res_valid_next && (mode_next != MODE_IDLE);
    end

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= 16'd1000;
            delay_reg      <= 16'd1;
            rounds_cfg_reg <= 7'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg    <= cfg_data;
                CFG_DELAY:   delay_reg      <= cfg_data;
                CFG_ROUNDS:  rounds_cfg_reg <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_IDLE;
            cur_ch_reg    <= '0;
            rounds_reg    <= '0;
            countdown_reg <= '0;
            ready_reg     <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cur_ch_reg    <= cur_ch_next;
            rounds_reg    <= rounds_next;
            countdown_reg <= countdown_next;
            ready_reg     <= ready_next;
            pos_reg       <= pos_next;
        end
    end

    // Register the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_req_reg   <= 1'b0;
            res_ch_reg    <= '0;
            res_stop_reg  <= 1'b0;
            res_busy_reg  <= 1'b0;
            res_state_reg <= CHST_BUSY;
            res_mean_reg  <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            res_req_reg   <= res_req_next;
            res_ch_reg    <= res_ch_next;
            res_stop_reg  <= res_stop_next;
            res_busy_reg  <= res_busy_next;
            res_state_reg <= res_state_next;
            res_mean_reg  <= res_mean_next;
        end
    end

    assign result_valid    = res_valid_reg;
    assign convert_request = res_req_reg;
    assign convert_channel = res_ch_reg;
    assign converter_stop  = res_stop_reg;
    assign busy_res        = res_busy_reg;
    assign channel_state   = res_state_reg;
    assign mean_value      = res_mean_reg;

    // No result word while an averaging pass is running
    a_no_result_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !result_valid)
        else $error("result word during averaging pass");

    // Start requests channel zero on the next cycle
    a_start_requests: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_START)) |=>
            (result_valid && convert_request && (convert_channel == 4'd0)))
        else $error("start did not request channel zero");

    // A converter stop always leaves the sequencer idle
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        converter_stop |-> (result_valid && !busy_res))
        else $error("converter stop with sequencer still busy");

    // A conversion request always leaves the sequencer running
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        convert_request |-> (result_valid && busy_res))
        else $error("conversion request with sequencer idle");

endmodule

// ----- tb/sv/scan_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the ADC scan sequencer: predicts the result word of each input word
// and checks what the block returns. Depends on asc_pkg for geometry and codes.
package scan_scoreboard_pkg;
    import asc_pkg::*;

    // Op codes that the block must ignore
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    localparam int unsigned ROUNDS_CAP = 127;

    typedef struct packed {
        logic        req;
        logic [3:0]  ch;
        logic        stop;
        logic        busy;
        logic [1:0]  status;
        logic [15:0] mean;
    } scan_result_t;

    class scan_scoreboard;
        // Sequencer state as the block should hold it
        logic [1:0]          mode;
        int unsigned         chan;
        int unsigned         rounds;
        int unsigned         countdown;
        logic [SAMPLE_W-1:0] ring [CHANNELS][RING_SIZE];
        int unsigned         fill [CHANNELS];
        bit                  ready [CHANNELS];

        // Register copies
        int unsigned conv_timeout;
        int unsigned chan_gap;
        int unsigned round_limit;

        // Expected result words, oldest first
        scan_result_t expected_q[$];

        int unsigned mismatches;
        int unsigned compared;
        int unsigned op_seen [8];
        int unsigned ready_reads;

        function new();
            conv_timeout = 1000;
            chan_gap     = 1;
            round_limit  = 16;
            mode         = MODE_IDLE;
            chan         = 0;
            rounds       = 0;
            countdown    = 0;
            mismatches   = 0;
            compared     = 0;
            ready_reads  = 0;
            foreach (op_seen[i])
            begin
                op_seen[i] = 0;
            end
            clear_rings();
        endfunction

        function void clear_rings();
            for (int c = 0; c < CHANNELS; c++)
            begin
                for (int i = 0; i < RING_SIZE; i++)
                begin
                    ring[c][i] = '0;
                end
                fill[c]  = 0;
                ready[c] = 1'b0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_TIMEOUT: conv_timeout = value;
                CFG_DELAY:   chan_gap     = value;
                CFG_ROUNDS:  round_limit  = value[6:0];
                default: ;
            endcase
        endfunction

        function bit any_ready();
            foreach (ready[c])
            begin
                if (ready[c])
                begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Advance the state by one accepted word and queue the result it must give
        function void note_word(logic [2:0] op, logic [SAMPLE_W-1:0] smp, logic [3:0] qch);
            scan_result_t r;
            bit           launch;
            bit           finished;
            int unsigned  sum;
            int unsigned  limit;
            r        = '0;
            launch   = 1'b0;
            finished = 1'b0;
            sum      = 0;
            limit    = (round_limit == 0) ? 1 : round_limit;
            op_seen[op]++;
            case (op)
                OP_START:
                begin
                    clear_rings();
                    chan   = 0;
                    rounds = 0;
                    launch = 1'b1;
                end
                OP_STOP:
                begin
                    r.stop = 1'b1;
                    mode   = MODE_IDLE;
                end
                OP_TICK:
                begin
                    if (mode == MODE_WAIT)
                    begin
                        // Conversion overdue: halt the converter
                        if (countdown <= 1)
                        begin
                            r.stop = 1'b1;
                            mode   = MODE_IDLE;
                        end
                        else
                        begin
                            countdown--;
                        end
                    end
                    else if (mode == MODE_DELAY)
                    begin
                        if (countdown <= 1)
                        begin
                            launch = 1'b1;
                        end
                        else
                        begin
                            countdown--;
                        end
                    end
                end
                OP_DONE:
                begin
                    if (mode == MODE_WAIT)
                    begin
                        // Store into the channel's ring; a wrap makes it ready
                        ring[chan][fill[chan]] = smp;
                        fill[chan]++;
                        if (fill[chan] >= RING_SIZE)
                        begin
                            fill[chan]  = 0;
                            ready[chan] = 1'b1;
                        end
                        chan++;
                        if (chan >= CHANNELS)
                        begin
                            chan = 0;
                            if (rounds < ROUNDS_CAP)
                            begin
                                rounds++;
                            end
                            finished = (rounds >= limit);
                        end
                        if (finished)
                        begin
                            mode = MODE_IDLE;
                        end
                        else if (chan_gap == 0)
                        begin
                            launch = 1'b1;
                        end
                        else
                        begin
                            mode      = MODE_DELAY;
                            countdown = chan_gap;
                        end
                    end
                end
                OP_QUERY:
                begin
                    if (qch >= CHANNELS)
                    begin
                        r.status = CHST_ERROR;
                        r.mean   = MEAN_NONE;
                    end
                    else if (!ready[qch])
                    begin
                        r.status = CHST_BUSY;
                        r.mean   = MEAN_NONE;
                    end
                    else
                    begin
                        for (int i = 0; i < RING_SIZE; i++)
                        begin
                            sum += ring[qch][i];
                        end
                        r.status = CHST_READY;
                        r.mean   = 16'((sum >> RING_LOG2) & 'h0FFF);
                        ready_reads++;
                    end
                end
                default: ;
            endcase
            if (launch)
            begin
                r.req     = 1'b1;
                r.ch      = chan[3:0];
                mode      = MODE_WAIT;
                countdown = conv_timeout;
            end
            r.busy = (mode != MODE_IDLE);
            expected_q.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH word %0d: %s", compared, what);
            mismatches++;
        endtask

        // Compare one result word against the oldest expectation
        task check_word(scan_result_t got);
            scan_result_t want;
            if (expected_q.size() == 0)
            begin
                report("result word with nothing pending");
                return;
            end
            want = expected_q.pop_front();
            if (got.req !== want.req)
            begin
                report($sformatf("convert_request %b, want %b", got.req, want.req));
            end
            if (got.ch !== want.ch)
            begin
                report($sformatf("convert_channel %0d, want %0d", got.ch, want.ch));
            end
            if (got.stop !== want.stop)
            begin
                report($sformatf("converter_stop %b, want %b", got.stop, want.stop));
            end
            if (got.busy !== want.busy)
            begin
                report($sformatf("busy_res %b, want %b", got.busy, want.busy));
            end
            if (got.status !== want.status)
            begin
                report($sformatf("channel_state %0d, want %0d", got.status, want.status));
            end
            if (got.mean !== want.mean)
            begin
                report($sformatf("mean_value %h, want %h", got.mean, want.mean));
            end
            compared++;
        endtask
    endclass

endpackage

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for adc_scan_sequencer_with_averaging_top: directed words, then
// random scans under several register settings. Depends on asc_pkg and scan_scoreboard_pkg.
module testbench;
    import asc_pkg::*;
    import scan_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                start         = 1'b0;
    logic [2:0]          op            = OP_TICK;
    logic [SAMPLE_W-1:0] sample        = '0;
    logic [3:0]          query_channel = '0;
    logic                cfg_we        = 1'b0;
    logic [1:0]          cfg_index     = CFG_TIMEOUT;
    logic [15:0]         cfg_data      = '0;
    logic                busy;
    logic                result_valid;
    logic                convert_request;
    logic [3:0]          convert_channel;
    logic                converter_stop;
    logic                busy_res;
    logic [1:0]          channel_state;
    logic [15:0]         mean_value;

    scan_scoreboard sb = new();
    scan_result_t   seen;
    int unsigned    cycle_count = 0;
    int unsigned    burst_left  = 0;
    bit             clean_scan  = 1'b1;

    adc_scan_sequencer_with_averaging_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .sample          (sample),
        .query_channel   (query_channel),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .convert_request (convert_request),
        .convert_channel (convert_channel),
        .converter_stop  (converter_stop),
        .busy_res        (busy_res),
        .channel_state   (channel_state),
        .mean_value      (mean_value)
    );

    always #4 clk = ~clk;

    // Check every result word in the cycle it is shown
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            seen.req    = convert_request;
            seen.ch     = convert_channel;
            seen.stop   = converter_stop;
            seen.busy   = busy_res;
            seen.status = channel_state;
            seen.mean   = mean_value;
            sb.check_word(seen);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Lower start and hold until every expected word has come back
    task automatic drain(int unsigned settle);
        start <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    // Idle the sender for a random gap; mostly short, some long, some bursts
    task automatic idle_after();
        int unsigned r;
        int unsigned gap;
        r   = $urandom_range(99);
        gap = 0;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else if (r < 2)
        begin
            drain(0);
        end
        else if (r < 6)
        begin
            burst_left = $urandom_range(40, 10);
        end
        else if (r < 50)
        begin
            gap = 0;
        end
        else if (r < 85)
        begin
            gap = $urandom_range(3, 1);
        end
        else if (r < 97)
        begin
            gap = $urandom_range(15, 4);
        end
        else
        begin
            gap = $urandom_range(80, 30);
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Present one word and hold it until the block takes it
    task automatic send_word(logic [2:0] o, logic [SAMPLE_W-1:0] s, logic [3:0] q);
        start         <= 1'b1;
        op            <= o;
        sample        <= s;
        query_channel <= q;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.note_word(o, s, q);
        idle_after();
    endtask

    task automatic load_settings(logic [15:0] tmo, logic [15:0] gap, logic [15:0] rnd);
        drain(4);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_index <= CFG_DELAY;
        cfg_data  <= gap;
        @(posedge clk);
        cfg_index <= CFG_ROUNDS;
        cfg_data  <= rnd;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(CFG_TIMEOUT, tmo);
        sb.set_reg(CFG_DELAY, gap);
        sb.set_reg(CFG_ROUNDS, rnd);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return '1;
        end
        else if (r < 18)
        begin
            return '0;
        end
        return SAMPLE_W'($urandom_range(4095, 0));
    endfunction

    // Mostly well-formed scans with random samples; some noise, stops and restarts
    task automatic send_random_word();
        int unsigned         r;
        logic [2:0]          o;
        logic [3:0]          q;
        logic [SAMPLE_W-1:0] s;
        r = $urandom_range(999);
        s = pick_sample();
        q = ($urandom_range(1) == 0) ? 4'($urandom_range(CHANNELS - 1, 0))
                                     : 4'($urandom_range(15, 0));
        o = OP_TICK;
        if (r < 15)
        begin
            o = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end
        else if (r < 95)
        begin
            o = OP_QUERY;
        end
        else if (!clean_scan && r < 125)
        begin
            o = OP_STOP;
        end
        else if (!clean_scan && r < 150)
        begin
            o = OP_START;
        end
        else
        begin
            case (sb.mode)
                MODE_IDLE:
                begin
                    if (sb.any_ready() && $urandom_range(1) == 1)
                    begin
                        o = OP_QUERY;
                        q = 4'($urandom_range(CHANNELS - 1, 0));
                    end
                    else
                    begin
                        o = OP_START;
                    end
                end
                MODE_WAIT:
                begin
                    if ($urandom_range(3) == 0 && !(clean_scan && sb.countdown <= 1))
                    begin
                        o = OP_TICK;
                    end
                    else
                    begin
                        o = OP_DONE;
                    end
                end
                default: o = OP_TICK;
            endcase
        end
        if (o == OP_START)
        begin
            clean_scan = ($urandom_range(9) < 7);
        end
        send_word(o, s, q);
    endtask

    task automatic run_random(int unsigned count);
        repeat (count)
        begin
            send_random_word();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under reset register values
        send_word(OP_QUERY, '0, 4'd0);
        send_word(OP_QUERY, '0, 4'd4);
        send_word(OP_QUERY, '1, 4'd15);
        send_word(OP_TICK, '0, 4'd0);
        send_word(OP_DONE, '1, 4'd0);
        send_word(OP_STOP, '0, 4'd0);
        send_word(OP_SPARE_LO, '1, 4'd15);
        send_word(OP_SPARE_MID, '0, 4'd0);
        send_word(OP_SPARE_HI, '1, 4'd15);
        send_word(OP_START, '0, 4'd0);
        send_word(OP_QUERY, '0, 4'd3);
        send_word(OP_TICK, '0, 4'd0);
        send_word(OP_DONE, '1, 4'd0);
        send_word(OP_DONE, 12'hABC, 4'd0);
        send_word(OP_TICK, '0, 4'd0);
        send_word(OP_DONE, '0, 4'd0);
        send_word(OP_START, '0, 4'd0);
        send_word(OP_DONE, 12'h555, 4'd0);
        send_word(OP_STOP, '0, 4'd0);
        send_word(OP_TICK, '0, 4'd0);
        run_random(180);

        // Lowest settings: immediate timeout, no channel delay, a single round
        load_settings(16'd1, 16'd0, 16'd1);
        send_word(OP_START, '0, 4'd0);
        send_word(OP_TICK, '0, 4'd0);
        send_word(OP_START, '0, 4'd0);
        send_word(OP_DONE, '1, 4'd0);
        run_random(60);

        // Highest timeout and channel delay, 64 scan rounds
        load_settings(16'hFFFF, 16'hFFFF, 16'd64);
        run_random(40);

        load_settings(16'd5, 16'd0, 16'd16);
        run_random(200);

        load_settings(16'd12, 16'd3, 16'd64);
        run_random(130);

        load_settings(16'd3, 16'd2, 16'd17);
        run_random(220);

        drain(30);
        $display("Run covered %0d starts, %0d stops, %0d ticks, %0d conversions, %0d spare ops",
                 sb.op_seen[OP_START], sb.op_seen[OP_STOP], sb.op_seen[OP_TICK],
                 sb.op_seen[OP_DONE],
                 sb.op_seen[OP_SPARE_LO] + sb.op_seen[OP_SPARE_MID] + sb.op_seen[OP_SPARE_HI]);
        $display("and %0d queries (%0d of ready channels); %0d words compared, %0d mismatches",
                 sb.op_seen[OP_QUERY], sb.ready_reads, sb.compared, sb.mismatches);
        if (sb.mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/asc_pkg.sv
rtl/core/asc_ring_mem.sv
rtl/core/asc_avg_unit.sv
rtl/core/adc_scan_sequencer_with_averaging_top.sv
tb/sv/scan_scoreboard_pkg.sv
tb/sv/testbench.sv
